[hw/rtl/tia_pkg.sv]
package tia_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam logic [7:0] LIFETIME_RESET = 8'd5;

   // opcodes of a request word
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_LOOK  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // status codes of a response word
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // csr register index (paddr[2])
   localparam logic REG_LIFETIME = 1'b0;

   typedef enum logic [1:0] {
      RES_ALLOC,
      RES_FULL,
      RES_BAD,
      RES_LOOK
   } res_kind_type;

   typedef struct packed {
      logic [15:0] query_id;
      logic [31:0] ipv4;
      logic [15:0] port;
      logic        done;
      logic [31:0] expiry;
   } row_type;

   localparam row_type ROW_RESET = '{query_id: 16'd0, ipv4: 32'd0, port: 16'd0,
                                     done: 1'b1, expiry: 32'd0};

   typedef struct packed {
      logic         capture;
      logic         read;
      logic         wr_alloc;
      logic         wr_look;
      logic         load_res;
      res_kind_type res_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic eval_vld;
      logic eligible;
      logic eval_last;
      logic tag_bad;
      logic out_free;
   } dp_sts_type;

endpackage

[hw/rtl/tia_if.sv]
interface tia_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] client_query_id;
   logic [31:0] client_ipv4;
   logic [15:0] client_udp_port;
   logic [15:0] relay_tag;

   modport source (output valid, opcode, client_query_id, client_ipv4, client_udp_port,
                   relay_tag, input ready);
   modport sink (input valid, opcode, client_query_id, client_ipv4, client_udp_port,
                 relay_tag, output ready);
endinterface

interface tia_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] assigned_tag;
   logic [15:0] restored_query_id;
   logic [31:0] restored_ipv4;
   logic [15:0] restored_port;

   modport source (output valid, status, assigned_tag, restored_query_id, restored_ipv4,
                   restored_port, input ready);
   modport sink (input valid, status, assigned_tag, restored_query_id, restored_ipv4,
                 restored_port, output ready);
endinterface

[hw/rtl/tia_ctrl.sv]
module tia_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_opcode,
   output logic                 req_ready,
   input  tia_pkg::dp_sts_type  sts,
   output tia_pkg::ctl_cmd_type cmd
);
   import tia_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LREAD,
      S_LWRITE,
      S_HOLD
   } state_type;

   state_type    state_ff, state_in;
   res_kind_type kind_ff, kind_in;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.res_kind = kind_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_opcode)
                  OP_ALLOC: state_in = S_SCAN;
                  OP_LOOK: begin
                     if (sts.tag_bad) begin
                        kind_in  = RES_BAD;
                        state_in = S_HOLD;
                     end else begin
                        state_in = S_LREAD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (sts.eval_vld && sts.eligible) begin
               cmd.wr_alloc = 1'b1;
               kind_in      = RES_ALLOC;
               state_in     = S_HOLD;
            end else if (sts.eval_vld && sts.eval_last) begin
               kind_in  = RES_FULL;
               state_in = S_HOLD;
            end else begin
               cmd.read = 1'b1;
            end
         end
         S_LREAD: begin
            cmd.read = 1'b1;
            state_in = S_LWRITE;
         end
         S_LWRITE: begin
            cmd.wr_look = 1'b1;
            kind_in     = RES_LOOK;
            state_in    = S_HOLD;
         end
         S_HOLD: begin
            if (sts.out_free) begin
               cmd.load_res = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= RES_FULL;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_res |-> sts.out_free)
      else $error("result loaded over a waiting word");

   a_alloc_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_alloc |-> (sts.eval_vld && sts.eligible && state_ff == S_SCAN))
      else $error("allocate write without an eligible slot");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && sts.eval_vld && sts.eval_last) |=> state_ff == S_HOLD)
      else $error("scan ran past the last slot");

   a_look_read: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_look |-> sts.eval_vld)
      else $error("lookup write without read data");

endmodule

[hw/rtl/tia_dpath.sv]
module tia_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_opcode,
   input  logic [15:0]          req_client_query_id,
   input  logic [31:0]          req_client_ipv4,
   input  logic [15:0]          req_client_udp_port,
   input  logic [15:0]          req_relay_tag,
   input  logic [7:0]           lifetime,
   input  tia_pkg::ctl_cmd_type cmd,
   output tia_pkg::dp_sts_type  sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_assigned_tag,
   output logic [15:0]          rsp_restored_query_id,
   output logic [31:0]          rsp_restored_ipv4,
   output logic [15:0]          rsp_restored_port
);
   import tia_pkg::*;

   row_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic [31:0]      sec_ff;
   logic [15:0]      qid_ff;
   logic [31:0]      ip_ff;
   logic [15:0]      port_ff;
   logic [IDX_W-1:0] addr_ff;
   logic [IDX_W-1:0] eval_ff;
   row_type          rd_data_ff;
   logic             rd_row_vld_ff;
   logic             rd_vld_ff;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       status_ff;
   logic [15:0]      tag_ff;
   logic [15:0]      rqid_ff;
   logic [31:0]      rip_ff;
   logic [15:0]      rport_ff;

   row_type     row_eff;
   row_type     row_new;
   logic [15:0] eval_tag;
   logic        stale;

   // never-written slots read as the reset row
   assign row_eff  = rd_row_vld_ff ? rd_data_ff : ROW_RESET;
   assign eval_tag = 16'(eval_ff) + 16'd1;
   assign stale    = (row_eff.expiry != 32'd0) && (row_eff.expiry < sec_ff);

   always_comb begin
      row_new = row_eff;
      if (cmd.wr_alloc) begin
         row_new.query_id = qid_ff;
         row_new.ipv4     = ip_ff;
         row_new.port     = port_ff;
         row_new.done     = 1'b0;
         row_new.expiry   = sec_ff + 32'(lifetime);
      end else begin
         row_new.done = 1'b1;
      end
   end

   assign sts.eval_vld  = rd_vld_ff;
   assign sts.eligible  = (stale || row_eff.done) && (row_eff.query_id != eval_tag);
   assign sts.eval_last = (eval_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign sts.tag_bad   = (req_relay_tag == 16'd0) ||
                          (req_relay_tag > 16'(TABLE_ENTRIES));
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   assign out_valid_in = cmd.load_res ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         sec_ff       <= 32'd0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture && req_opcode == OP_TICK) begin
            sec_ff <= sec_ff + 32'd1;
         end
         if (cmd.wr_alloc || cmd.wr_look) begin
            valid_ff[eval_ff] <= 1'b1;
         end
         rd_vld_ff    <= cmd.read;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         qid_ff  <= req_client_query_id;
         ip_ff   <= req_client_ipv4;
         port_ff <= req_client_udp_port;
         addr_ff <= (req_opcode == OP_LOOK) ? IDX_W'(req_relay_tag - 16'd1) : '0;
      end else if (cmd.read) begin
         addr_ff <= addr_ff + IDX_W'(1);
      end
      if (cmd.read) begin
         eval_ff <= addr_ff;
      end
   end

   // table storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_alloc || cmd.wr_look) begin
         mem[eval_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff    <= mem[addr_ff];
         rd_row_vld_ff <= valid_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_res) begin
         status_ff <= ST_OK;
         tag_ff    <= 16'd0;
         rqid_ff   <= 16'd0;
         rip_ff    <= 32'd0;
         rport_ff  <= 16'd0;
         case (cmd.res_kind)
            RES_ALLOC: tag_ff <= eval_tag;
            RES_FULL:  status_ff <= ST_FULL;
            RES_BAD:   status_ff <= ST_BAD;
            RES_LOOK: begin
               rqid_ff  <= row_eff.query_id;
               rip_ff   <= row_eff.ipv4;
               rport_ff <= row_eff.port;
            end
            default: status_ff <= ST_BAD;
         endcase
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_assigned_tag      = tag_ff;
   assign rsp_restored_query_id = rqid_ff;
   assign rsp_restored_ipv4     = rip_ff;
   assign rsp_restored_port     = rport_ff;

endmodule

[hw/rtl/transaction_id_allocator.sv]
// Relay ID allocator: maps client DNS queries to relay tags (slot index plus one) and back.
// Request words: opcode 0 allocates a slot for (query ID, IPv4, port), opcode 1 looks up a
// relay tag from a server response and marks the slot finished, opcode 2 advances the
// seconds counter by one and opcode 3 is dropped; ticks and opcode 3 give no response word.
// Allocate scans the table from slot 0, one slot per clock through the table RAM's single
// read port, until it finds a free slot or has read the last one; a lookup reads its slot
// and writes it back, and an out-of-range tag skips the table. A finished word waits in
// its hold state while the output register still holds an untaken response. One word is
// worked on at a time; a finished response sits in the output register while the next
// request is taken.
// Entry lifetime (seconds) is the register at csr address 0, reset 5; write it while idle.
// No clearing pass after reset: per-slot valid flops make unwritten slots read as free.
module transaction_id_allocator (
   input  logic              clock,
   input  logic              reset,
   tia_req_if.sink           req,
   tia_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import tia_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   logic [7:0] lifetime_ff;
   logic       csr_wr;

   // csr: single register, pready held high
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LIFETIME_RESET;
      end else if (csr_wr && paddr[2] == REG_LIFETIME) begin
         lifetime_ff <= pwdata[7:0];
      end
   end

   // reads of an unmapped address return zero
   assign prdata = (paddr[2] == REG_LIFETIME) ? {24'd0, lifetime_ff} : 32'd0;

   // sequencer: accept, table scan / lookup, response hand-off
   tia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (req.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // table RAM, seconds counter, item and response registers
   tia_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .req_opcode            (req.opcode),
      .req_client_query_id   (req.client_query_id),
      .req_client_ipv4       (req.client_ipv4),
      .req_client_udp_port   (req.client_udp_port),
      .req_relay_tag         (req.relay_tag),
      .lifetime              (lifetime_ff),
      .cmd                   (cmd),
      .sts                   (sts),
      .rsp_valid             (rsp.valid),
      .rsp_ready             (rsp.ready),
      .rsp_status            (rsp.status),
      .rsp_assigned_tag      (rsp.assigned_tag),
      .rsp_restored_query_id (rsp.restored_query_id),
      .rsp_restored_ipv4     (rsp.restored_ipv4),
      .rsp_restored_port     (rsp.restored_port)
   );

endmodule

[tb/tag_table_checker.sv]
module tag_table_checker (
   input  logic        clock,
   input  logic        reset,
   tia_req_if          req,
   tia_rsp_if          rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          replies_left
);
   timeunit 1ns;
   timeprecision 1ps;

   import tia_pkg::*;

   localparam int SHOWN_MAX = 10;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] tag;
      logic [15:0] query_id;
      logic [31:0] ipv4;
      logic [15:0] port;
   } reply_type;

   // shadow copy of the relay table
   logic [15:0] slot_qid    [TABLE_ENTRIES];
   logic [31:0] slot_ipv4   [TABLE_ENTRIES];
   logic [15:0] slot_port   [TABLE_ENTRIES];
   logic        slot_done   [TABLE_ENTRIES];
   logic [31:0] slot_expiry [TABLE_ENTRIES];
   logic [31:0] seconds_now;
   logic [7:0]  lifetime;
   reply_type   replies_due[$];

   // applies one request word to the shadow table; 1 when it yields a reply word
   function automatic bit table_step(input logic [1:0] op, input logic [15:0] qid,
                                     input logic [31:0] ip, input logic [15:0] port,
                                     input logic [15:0] tag, output reply_type r);
      bit stale;
      int idx;
      r = '0;
      case (op)
         OP_TICK: begin
            seconds_now = seconds_now + 32'd1;
            return 1'b0;
         end
         OP_ALLOC: begin
            r.status = ST_FULL;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               stale = slot_expiry[i] != 32'd0 && slot_expiry[i] < seconds_now;
               // a slot holding its own tag as client ID is never reused
               if ((stale || slot_done[i]) && int'(slot_qid[i]) != i + 1) begin
                  slot_qid[i]    = qid;
                  slot_ipv4[i]   = ip;
                  slot_port[i]   = port;
                  slot_done[i]   = 1'b0;
                  slot_expiry[i] = seconds_now + 32'(lifetime);
                  r.status = ST_OK;
                  r.tag    = 16'(i + 1);
                  return 1'b1;
               end
            end
            return 1'b1;
         end
         OP_LOOK: begin
            if (tag == 16'd0 || int'(tag) > TABLE_ENTRIES) begin
               r.status = ST_BAD;
               return 1'b1;
            end
            idx = int'(tag) - 1;
            r.status   = ST_OK;
            r.query_id = slot_qid[idx];
            r.ipv4     = slot_ipv4[idx];
            r.port     = slot_port[idx];
            slot_done[idx] = 1'b1;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void note_failure(input string what, input reply_type want,
                                        input reply_type got);
      fail_count++;
      // fields: status/tag/query id/ipv4/port
      if (fail_count <= SHOWN_MAX)
         $display("%0t %s: want %0d/%0d/%h/%h/%h got %0d/%0d/%h/%h/%h", $time, what,
                  want.status, want.tag, want.query_id, want.ipv4, want.port,
                  got.status, got.tag, got.query_id, got.ipv4, got.port);
   endfunction

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      reply_type fresh;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_qid[i]    = '0;
            slot_ipv4[i]   = '0;
            slot_port[i]   = '0;
            slot_done[i]   = 1'b1;
            slot_expiry[i] = '0;
         end
         seconds_now = '0;
         lifetime    = LIFETIME_RESET;
         replies_due.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_LIFETIME)
            lifetime = pwdata[7:0];
         // check the outgoing word before queuing a new one
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.status, rsp.assigned_tag, rsp.restored_query_id,
                    rsp.restored_ipv4, rsp.restored_port};
            if (replies_due.size() == 0) begin
               note_failure("unexpected word", '0, got);
            end else begin
               want = replies_due.pop_front();
               if (got !== want)
                  note_failure("mismatch", want, got);
            end
         end
         if (req.valid && req.ready) begin
            if (table_step(req.opcode, req.client_query_id, req.client_ipv4,
                           req.client_udp_port, req.relay_tag, fresh))
               replies_due.push_back(fresh);
         end
      end
      replies_left = replies_due.size();
   end

endmodule

[tb/transaction_id_allocator_tb.sv]
module transaction_id_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tia_pkg::*;

   // opcode the block drops without a reply
   localparam logic [1:0] OP_SPARE       = 2'd3;
   localparam logic [2:0] LIFETIME_ADDR  = {REG_LIFETIME, 2'b00};
   localparam int         RANDOM_WORDS   = 350;   // per random phase
   localparam int         HOLD_CYCLES    = 300;   // long receiver back-pressure
   localparam int         SETTLE_CYCLES  = 8;     // ticks/spare words finish within this
   // slowest legal gap: a full-table scan plus both sides' idling, or the long
   // hold plus one scan; the limit is several times that
   localparam int         WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int replies_left;
   int words_due;        // reply-producing words accepted by the block
   int words_back;       // reply words taken by the receiver
   int send_calm;        // words left in a no-idle stretch, sender side
   int recv_calm;        // same, receiver side
   int quiet_cycles;
   int n_alloc, n_look, n_tick, n_spare, n_writes;
   bit rsp_hold_due;     // asks the receiver for one long hold-off

   tia_req_if req_if();
   tia_rsp_if rsp_if();

   transaction_id_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   tag_table_checker table_check (
      .clock        (clock),
      .reset        (reset),
      .req          (req_if),
      .rsp          (rsp_if),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .pready       (pready),
      .fail_count   (fail_count),
      .replies_left (replies_left)
   );

   always #5 clock = ~clock;

   // idle cycles before the next word, drawn at random, with occasional no-idle stretches
   function automatic int draw_gap(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         calm_left = $urandom_range(8, 40);
      return $urandom_range(0, 3);
   endfunction

   // offer one request word and hold it until the block takes it
   task automatic send_word(input logic [1:0] op, input logic [15:0] qid,
                            input logic [31:0] ip, input logic [15:0] port,
                            input logic [15:0] tag);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.opcode          <= op;
      req_if.client_query_id <= qid;
      req_if.client_ipv4     <= ip;
      req_if.client_udp_port <= port;
      req_if.relay_tag       <= tag;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      case (op)
         OP_ALLOC: begin
            n_alloc++;
            words_due++;
         end
         OP_LOOK: begin
            n_look++;
            words_due++;
         end
         OP_TICK: n_tick++;
         default: n_spare++;
      endcase
   endtask

   // random word; lookups mostly aim at the low tags the scan hands out first
   task automatic send_random_word(input int span);
      int          pick;
      logic [15:0] qid;
      logic [15:0] tag;
      pick = $urandom_range(0, 99);
      qid  = 16'($urandom);
      // client ID equal to some slot's own tag: if it lands in that slot, the slot gets locked out
      if ($urandom_range(0, 15) == 0)
         qid = 16'($urandom_range(1, TABLE_ENTRIES));
      case ($urandom_range(0, 19))
         0:       tag = 16'd0;
         1:       tag = 16'hFFFF;
         2:       tag = 16'($urandom_range(TABLE_ENTRIES + 1, 65535));
         3, 4, 5: tag = 16'($urandom_range(1, TABLE_ENTRIES));
         default: tag = 16'($urandom_range(1, span));
      endcase
      if (pick < 45)
         send_word(OP_ALLOC, qid, $urandom, 16'($urandom), 16'($urandom));
      else if (pick < 82)
         send_word(OP_LOOK, qid, $urandom, 16'($urandom), tag);
      else if (pick < 95)
         send_word(OP_TICK, qid, $urandom, 16'($urandom), 16'($urandom));
      else
         send_word(OP_SPARE, qid, $urandom, 16'($urandom), tag);
   endtask

   // stop offering and wait until every reply word is back and the block is quiet
   task automatic drain_replies();
      req_if.valid <= 1'b0;
      while (words_back != words_due) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of the lifetime register, only with the block idle
   task automatic set_lifetime(input logic [7:0] value);
      drain_replies();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIFETIME_ADDR;
      pwdata  <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      n_writes++;
   endtask

   // receiver: random ready gaps, plus one long hold-off on request so the
   // output register and the working slot fill and the input stalls
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(recv_calm);
         if (rsp_hold_due) begin
            rsp_hold_due = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         words_back++;
      end
   end

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                  <= 1'b1;
      psel                   <= 1'b0;
      penable                <= 1'b0;
      pwrite                 <= 1'b0;
      paddr                  <= '0;
      pwdata                 <= '0;
      req_if.valid           <= 1'b0;
      req_if.opcode          <= OP_ALLOC;
      req_if.client_query_id <= '0;
      req_if.client_ipv4     <= '0;
      req_if.client_udp_port <= '0;
      req_if.relay_tag       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed, lifetime at its reset value of 5 ---
      send_word(OP_ALLOC, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000); // slot 0, zeros
      send_word(OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF); // slot 1, all ones
      // client ID 3 lands in slot 2, whose tag is also 3
      send_word(OP_ALLOC, 16'h0003, 32'hA5A5_5A5A, 16'h5A5A, 16'h0000);
      send_word(OP_LOOK,  16'h0000, 32'h0000_0000, 16'h0000, 16'd3);    // finishes slot 2
      // slot 2 is finished but locked by its own tag, so slot 3 is taken
      send_word(OP_ALLOC, 16'h1234, 32'h0102_0304, 16'd53,   16'h0000);
      send_word(OP_LOOK,  16'h0000, 32'h0000_0000, 16'h0000, 16'd1);    // unfinished slot
      send_word(OP_LOOK,  16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd1);    // already finished
      send_word(OP_LOOK,  16'h0000, 32'h0000_0000, 16'h0000, 16'd0);    // tag zero
      send_word(OP_LOOK,  16'h0000, 32'h0000_0000, 16'h0000, 16'(TABLE_ENTRIES + 1));
      send_word(OP_LOOK,  16'h0000, 32'h0000_0000, 16'h0000, 16'hFFFF);
      send_word(OP_LOOK,  16'h0000, 32'h0000_0000, 16'h0000, 16'(TABLE_ENTRIES)); // top slot
      send_word(OP_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF); // dropped
      // seven seconds pass: slots 1 and 3 (expiry 5) go stale
      repeat (7) send_word(OP_TICK, 16'h0000, 32'h0000_0000, 16'h0000, 16'h0000);
      send_word(OP_ALLOC, 16'hBEEF, 32'hC0A8_0001, 16'd1024, 16'h0000); // finished slot 0
      send_word(OP_ALLOC, 16'h8001, 32'h7F00_0001, 16'd8080, 16'h0000); // stale slot 1
      send_word(OP_LOOK,  16'h0000, 32'h0000_0000, 16'h0000, 16'd2);
      send_word(OP_ALLOC, 16'h0001, 32'h0A00_0001, 16'd1,    16'h0000); // slot 1, finished

      // --- shortest lifetime: heavy stale reuse ---
      set_lifetime(8'd1);
      repeat (RANDOM_WORDS) send_random_word(8);

      // --- longest lifetime: fill the table past full, then finish every slot ---
      set_lifetime(8'd255);
      repeat (TABLE_ENTRIES + 6)
         send_word(OP_ALLOC, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
      for (int t = 1; t <= TABLE_ENTRIES; t++)
         send_word(OP_LOOK, 16'($urandom), $urandom, 16'($urandom), 16'(t));
      // receiver stalls for a long stretch while the sender keeps offering
      rsp_hold_due = 1'b1;
      repeat (RANDOM_WORDS) send_random_word(32);

      // --- mid-range lifetime ---
      set_lifetime(8'($urandom_range(2, 254)));
      repeat (RANDOM_WORDS) send_random_word(64);

      // --- back to the reset value ---
      set_lifetime(LIFETIME_RESET);
      repeat (RANDOM_WORDS) send_random_word(16);

      drain_replies();
      $display("covered %0d allocate, %0d lookup, %0d tick, %0d dropped words; %0d replies",
               n_alloc, n_look, n_tick, n_spare, words_back);
      $display("lifetime written %0d times (1, 255, mid, 5), table filled past full once",
               n_writes);
      if (fail_count == 0 && replies_left == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d failures, %0d replies never seen", fail_count, replies_left);
         $display("status: fail");
      end
      $finish;
   end

endmodule
